### hdl/hvl_pkg.sv
// Shared constants for the hashed key-vector lookup-or-insert block.
package hvl_pkg;

  localparam int KEY_SLOTS = 9;
  localparam int ELEM_W = 5;
  localparam int ELEM_MAX = (1 << ELEM_W) - 1;
  localparam int ENTRY_W = 12;
  localparam int HASH_MUL = 101;

  localparam int BUCKET_COUNT_DEF = 1021;
  localparam int STORE_DEPTH_DEF = 4096;
  localparam int KEY_LENGTH_DEF = 9;

  localparam logic ACT_FIND = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef logic [ELEM_W-1:0] elem_t;

endpackage

### hdl/hvl_in_if.sv
// Input channel carrying one action and one key vector per beat.
interface hvl_in_if
  import hvl_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  action;
  elem_t key_0;
  elem_t key_1;
  elem_t key_2;
  elem_t key_3;
  elem_t key_4;
  elem_t key_5;
  elem_t key_6;
  elem_t key_7;
  elem_t key_8;

  modport source (
    output valid, action, key_0, key_1, key_2, key_3, key_4, key_5, key_6, key_7, key_8,
    input  ready
  );
  modport sink (
    input  valid, action, key_0, key_1, key_2, key_3, key_4, key_5, key_6, key_7, key_8,
    output ready
  );
endinterface

### hdl/hvl_out_if.sv
// Result channel carrying one entry number and its flags per beat.
interface hvl_out_if
  import hvl_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] entry_number;
  logic               was_new;
  logic               store_full;

  modport source (
    output valid, entry_number, was_new, store_full,
    input  ready
  );
  modport sink (
    input  valid, entry_number, was_new, store_full,
    output ready
  );
endinterface

### hdl/hashed_vector_lookup_or_insert.sv
// Key-vector interning table: hashes a key, walks its bucket chain, inserts on a miss.
//
// Every input beat on in_ch gives exactly one result beat on out_ch. A beat with
// action set to clear empties all buckets and zeroes the entry count; its result
// is entry 0 with both flags low. Any other beat looks up the first KEY_LENGTH
// key elements and returns the existing entry number, or stores the key as the
// next entry and raises was_new, or raises store_full when no entry is free.
// One item is worked on at a time and in_ch.ready is high only while idle.
// A lookup runs each key element through the shared hash unit (multiply by
// 101, reciprocal quotient, remainder), fetches the bucket head, compares
// one chain entry at a time (registered memory read), and on a miss
// stores the key or flags store_full. A hit goes straight to the output
// register after its compare. A clear makes a pass over the bucket heads;
// after reset the same pass runs with in_ch.ready low.
// The result sits in an output register; while out_ch.ready stays low the
// finished item waits there and no new beat is taken once the next one is done.
module hashed_vector_lookup_or_insert
  import hvl_pkg::*;
#(
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int KEY_LENGTH = KEY_LENGTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  hvl_in_if.sink    in_ch,
  hvl_out_if.source out_ch
);

  localparam int HW = $clog2(BUCKET_COUNT);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = AW + 1;
  localparam int KW = KEY_LENGTH * ELEM_W;
  localparam int IW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
  localparam int XMAX = (BUCKET_COUNT - 1) * HASH_MUL + ELEM_MAX;
  localparam int XW = $clog2(XMAX + 1);
  localparam int MW = XW - HW + 1;
  localparam int WW = XW + MW;
  localparam int RW = HW + 1;
  localparam longint RECIP = (longint'(1) << XW) / BUCKET_COUNT;

  localparam logic [3:0] ST_SWEEP  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_MIX    = 4'd2;
  localparam logic [3:0] ST_QUOT   = 4'd3;
  localparam logic [3:0] ST_REM    = 4'd4;
  localparam logic [3:0] ST_BUCKET = 4'd5;
  localparam logic [3:0] ST_HEAD   = 4'd6;
  localparam logic [3:0] ST_LOAD   = 4'd7;
  localparam logic [3:0] ST_CHECK  = 4'd8;
  localparam logic [3:0] ST_CMP    = 4'd9;
  localparam logic [3:0] ST_MISS   = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [HW-1:0] sweep_r, sweep_nxt;
  logic          reply_r, reply_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;

  elem_t         key_r [KEY_LENGTH];
  logic [IW-1:0] idx_r, idx_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [MW-1:0] q_r, q_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic [HW-1:0] bucket_r, bucket_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] res_num_r, res_num_nxt;
  logic          res_new_r, res_new_nxt;
  logic          res_full_r, res_full_nxt;
  logic [ENTRY_W-1:0] out_num_r;
  logic          out_new_r;
  logic          out_full_r;

  elem_t         in_key [KEY_SLOTS];
  logic          key_load;
  logic          out_load;
  logic [KW-1:0] key_flat;
  logic [RW-1:0] r_fix;
  elem_t         elem;
  logic [WW-1:0] xm;
  logic [WW-1:0] diff;
  logic [ENTRY_W+CW-1:0] num_ext;

  logic [CW-1:0]    head_mem [BUCKET_COUNT];
  logic [CW-1:0]    head_q;
  logic             head_we;
  logic [HW-1:0]    head_wa;
  logic [CW-1:0]    head_wd;
  logic [KW+CW-1:0] ent_mem [STORE_DEPTH];
  logic [KW+CW-1:0] ent_q;
  logic             ent_we;
  logic [KW-1:0]    ent_key;
  logic [CW-1:0]    ent_link;

  assign in_key[0] = in_ch.key_0;
  assign in_key[1] = in_ch.key_1;
  assign in_key[2] = in_ch.key_2;
  assign in_key[3] = in_ch.key_3;
  assign in_key[4] = in_ch.key_4;
  assign in_key[5] = in_ch.key_5;
  assign in_key[6] = in_ch.key_6;
  assign in_key[7] = in_ch.key_7;
  assign in_key[8] = in_ch.key_8;

  always_comb begin
    for (int i = 0; i < KEY_LENGTH; i++) begin
      key_flat[i*ELEM_W +: ELEM_W] = key_r[i];
    end
  end

  // Shared hash unit: remainder correction, multiply-add, reciprocal quotient, remainder.
  assign r_fix = (r_r >= RW'(BUCKET_COUNT)) ? (r_r - RW'(BUCKET_COUNT)) : r_r;
  assign elem  = key_r[idx_r];
  assign xm    = WW'(x_r) * WW'(RECIP);
  assign diff  = WW'(x_r) - WW'(q_r) * WW'(BUCKET_COUNT);

  assign ent_key  = ent_q[KW+CW-1:CW];
  assign ent_link = ent_q[CW-1:0];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign key_load = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    sweep_nxt    = sweep_r;
    reply_nxt    = reply_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    x_nxt        = x_r;
    q_nxt        = q_r;
    r_nxt        = r_r;
    bucket_nxt   = bucket_r;
    k_nxt        = k_r;
    steps_nxt    = steps_r;
    res_num_nxt  = res_num_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;
    head_we      = 1'b0;
    head_wa      = bucket_r;
    head_wd      = count_r;
    ent_we       = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_SWEEP: begin
        head_we   = 1'b1;
        head_wa   = sweep_r;
        head_wd   = CW'(STORE_DEPTH);
        count_nxt = '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == HW'(BUCKET_COUNT - 1)) begin
          sweep_nxt = '0;
          state_nxt = reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (key_load) begin
          res_num_nxt  = '0;
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          idx_nxt      = '0;
          r_nxt        = '0;
          if (in_ch.action == ACT_CLEAR) begin
            reply_nxt = 1'b1;
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_MIX;
          end
        end
      end
      ST_MIX: begin
        x_nxt     = XW'(r_fix) * XW'(HASH_MUL) + XW'(elem);
        state_nxt = ST_QUOT;
      end
      ST_QUOT: begin
        q_nxt     = xm[WW-1:XW];
        state_nxt = ST_REM;
      end
      ST_REM: begin
        r_nxt = diff[RW-1:0];
        if (idx_r == IW'(KEY_LENGTH - 1)) begin
          state_nxt = ST_BUCKET;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_MIX;
        end
      end
      ST_BUCKET: begin
        bucket_nxt = r_fix[HW-1:0];
        state_nxt  = ST_HEAD;
      end
      ST_HEAD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        k_nxt     = head_q;
        steps_nxt = '0;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if ((k_r < count_r) && (steps_r <= count_r)) begin
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_MISS;
        end
      end
      ST_CMP: begin
        if (ent_key == key_flat) begin
          res_num_nxt = k_r;
          state_nxt   = ST_DONE;
        end else begin
          k_nxt     = ent_link;
          steps_nxt = steps_r + 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_MISS: begin
        if (count_r >= CW'(STORE_DEPTH)) begin
          res_full_nxt = 1'b1;
        end else begin
          ent_we      = 1'b1;
          head_we     = 1'b1;
          head_wa     = bucket_r;
          head_wd     = count_r;
          count_nxt   = count_r + 1'b1;
          res_num_nxt = count_r;
          res_new_nxt = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          reply_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign num_ext = {{ENTRY_W{1'b0}}, res_num_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      reply_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      reply_r     <= reply_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    x_r        <= x_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    bucket_r   <= bucket_nxt;
    k_r        <= k_nxt;
    steps_r    <= steps_nxt;
    res_num_r  <= res_num_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    if (key_load) begin
      for (int i = 0; i < KEY_LENGTH; i++) begin
        key_r[i] <= in_key[i];
      end
    end
    if (out_load) begin
      out_num_r  <= num_ext[ENTRY_W-1:0];
      out_new_r  <= res_new_r;
      out_full_r <= res_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_q <= head_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[count_r[AW-1:0]] <= {key_flat, head_q};
    end
    ent_q <= ent_mem[k_r[AW-1:0]];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.entry_number = out_num_r;
  assign out_ch.was_new      = out_new_r;
  assign out_ch.store_full   = out_full_r;

endmodule
